### hw/rtl/sida_pkg.sv
// Package: shared types, constants and double-dabble step for the decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package sida_pkg;

	localparam int unsigned BIN_W          = 32;
	localparam int unsigned NUM_DIGITS     = 10;
	localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
	localparam int unsigned STEPS_PER_STAGE = 8;
	localparam int unsigned NUM_DABBLE     = BIN_W / STEPS_PER_STAGE;
	localparam int unsigned IDX_W          = 4;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
		logic [BIN_W-1:0] bin;
	} item_t;

	// One double-dabble step: add-3 correction on every digit, then shift one binary bit in.
	function automatic item_t dabble_step(input item_t d);
		item_t r;
		logic [BCD_W-1:0] adj;
		adj = d.bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (adj[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
			end
		end
		r.neg = d.neg;
		r.bcd = {adj[BCD_W-2:0], d.bin[BIN_W-1]};
		r.bin = {d.bin[BIN_W-2:0], 1'b0};
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/sida_dabble_stage.sv
// One pipeline stage of the binary-to-BCD conversion, several dabble steps deep.
`timescale 1ns / 1ps
`default_nettype none
module sida_dabble_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire sida_pkg::item_t in_data,
	output logic                in_ready,
	output logic                out_valid,
	output sida_pkg::item_t     out_data,
	input  wire logic           out_ready
);

	logic            valid_q;
	sida_pkg::item_t data_q;
	sida_pkg::item_t next_data;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		next_data = in_data;
		for (int s = 0; s < sida_pkg::STEPS_PER_STAGE; s++) begin
			next_data = sida_pkg::dabble_step(next_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii.sv
// The first character passes the sign stage, four dabble stages, the serializer load and the
// output register. One character leaves per cycle while out_stall is low; an item is 1 to 11
// characters (digits plus sign), the most for a full-width negative number.
// The output serializer is what sets the rate; the pipeline ahead of it takes a word per cycle
// while the serializer is not holding it back.
// Reset clears all valid bits and the serializer state; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       char_code,
	output logic             last_char
);

	localparam int unsigned N = sida_pkg::NUM_DABBLE;

	// sign / magnitude stage
	logic            valid_s1;
	sida_pkg::item_t data_s1;
	logic            ready_s1;

	logic            stg_valid [0:N];
	sida_pkg::item_t stg_data  [0:N];
	logic            stg_ready [0:N];

	// stg_ready[0] is the input-ready of the first dabble stage
	assign ready_s1 = !valid_s1 || stg_ready[0];
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			data_s1.neg <= value[31];
			data_s1.bin <= value[31] ? (32'd0 - value) : value;
			data_s1.bcd <= '0;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_data[0]  = data_s1;

	for (genvar g = 0; g < N; g++) begin : g_dabble
		sida_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_data   (stg_data[g]),
			.in_ready  (stg_ready[g]),
			.out_valid (stg_valid[g+1]),
			.out_data  (stg_data[g+1]),
			.out_ready (stg_ready[g+1])
		);
	end

	// output serializer
	logic                                busy_q;
	logic                                minus_q;
	logic [sida_pkg::IDX_W-1:0]          idx_q;
	logic [sida_pkg::BCD_W-1:0]          digits_q;
	logic                                out_valid_q;
	logic [7:0]                          char_q;
	logic                                last_q;
	logic                                adv;
	logic                                finishing;
	logic                                load;
	logic [sida_pkg::IDX_W-1:0]          top_idx;
	logic [3:0]                          cur_digit;

	assign adv       = !out_valid_q || !out_stall;
	assign finishing = busy_q && adv && !minus_q && (idx_q == '0);
	assign load      = stg_valid[N] && (!busy_q || finishing);
	assign stg_ready[N] = !busy_q || finishing;
	assign cur_digit = digits_q[idx_q*4 +: 4];

	// highest nonzero digit; zero gives a single digit
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < sida_pkg::NUM_DIGITS; i++) begin
			if (stg_data[N].bcd[i*4 +: 4] != 4'd0) begin
				top_idx = sida_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			minus_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
				if (busy_q) begin
					if (minus_q) begin
						char_q  <= sida_pkg::ASCII_MINUS;
						last_q  <= 1'b0;
						minus_q <= 1'b0;
					end else begin
						char_q <= sida_pkg::ASCII_ZERO + {4'd0, cur_digit};
						last_q <= (idx_q == '0);
						if (idx_q == '0) begin
							busy_q <= 1'b0;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
			end
			if (load) begin
				busy_q  <= 1'b1;
				minus_q <= stg_data[N].neg;
				idx_q   <= top_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= stg_data[N].bcd;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == sida_pkg::ASCII_MINUS) |-> !last_q)
		else $error("minus sign marked as last character");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < sida_pkg::IDX_W'(sida_pkg::NUM_DIGITS)))
		else $error("digit index out of range");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q)
		else $error("serializer not busy after load");

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted word lost at first stage");

endmodule
`default_nettype wire

### bench/signed_int_to_decimal_ascii_tb.sv
// Testbench for the decimal text converter: directed and random words, checked per character.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_tb;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  char_code;
	logic        last_char;

	text_char_t  expected_text[$];
	int          sender_idle_pct;
	int          receiver_idle_pct;
	logic        hold_request;
	int          hold_left;
	int          mismatches;
	int          words_sent;
	int          negative_words;
	int          chars_checked;
	int          input_stall_cycles;

	signed_int_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Queue the characters that one word should turn into, most significant first.
	function automatic void predict_text(input logic [31:0] word);
		logic        neg;
		logic [31:0] mag;
		logic [31:0] rem;
		logic [7:0]  digits[$];
		text_char_t  c;
		neg = word[31];
		mag = neg ? (32'd0 - word) : word;
		do begin
			rem = mag % 32'd10;
			digits.push_front(sida_pkg::ASCII_ZERO + rem[7:0]);
			mag = mag / 32'd10;
		end while (mag != 32'd0);
		if (neg) begin
			c.code = sida_pkg::ASCII_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
			negative_words++;
		end
		foreach (digits[i]) begin
			c.code = digits[i];
			c.last = (i == digits.size() - 1);
			expected_text.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%t mismatch: %s", $realtime, what);
		end
	endtask

	// Called at a rising edge; returns at the rising edge where the word was taken.
	task automatic send_word(input logic [31:0] word);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= word;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		predict_text(word);
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Half the time numbers of a chosen digit count, so short and long texts both show up often.
	function automatic logic [31:0] random_word();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] w;
		int          ndig;
		case ($urandom_range(3))
			0: w = $urandom;
			1: w = $urandom_range(999);
			default: begin
				ndig = $urandom_range(1, 10);
				lo = 32'd1;
				repeat (ndig - 1) lo = lo * 32'd10;
				hi = (ndig == 10) ? 32'd2147483647 : lo * 32'd10 - 32'd1;
				if (ndig == 1) lo = 32'd0;
				w = $urandom_range(hi, lo);
			end
		endcase
		if ($urandom_range(1)) w = 32'd0 - w;
		return w;
	endfunction

	task automatic test_directed();
		logic [31:0] words[$];
		words = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
			-32'sd999999999, -32'sd1000000000, 32'd1999999999, 32'd123456789,
			-32'sd123456789, 32'd5, -32'sd5, 32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555};
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		foreach (words[i]) send_word(words[i]);
		wait_drained();
	endtask

	task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
		sender_idle_pct = snd_pct;
		receiver_idle_pct = rcv_pct;
		repeat (count) send_word(random_word());
		wait_drained();
	endtask

	// Receiver holds off long enough for the pipeline to fill and push back on the input.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_request = 1'b1;
		repeat (30) send_word(32'h8000_0000 | $urandom);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = 250;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (receiver_idle_pct != 0) && ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Sample at the falling edge, after the drive edge, so handshake decisions are settled.
	always @(negedge clk) begin : check_chars
		text_char_t want;
		if (arst_n && in_valid && in_stall) input_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected char %0d last %0b", char_code, last_char));
			end else begin
				want = expected_text.pop_front();
				chars_checked++;
				if (char_code !== want.code || last_char !== want.last) begin
					report_mismatch($sformatf("expected char %0d last %0b, got char %0d last %0b",
						want.code, want.last, char_code, last_char));
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d chars still expected", expected_text.size());
		$display("signed_int_to_decimal_ascii_tb: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = 32'd0;
		out_stall = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		mismatches = 0;
		words_sent = 0;
		negative_words = 0;
		chars_checked = 0;
		input_stall_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(55, 38, 69);
		test_random(55, 69, 38);
		test_random(55, 0, 0);
		test_backpressure();

		if (expected_text.size() != 0) begin
			report_mismatch($sformatf("%0d chars never arrived", expected_text.size()));
		end
		$display("%0d words converted (%0d negative), %0d chars checked, %0d mismatches",
			words_sent, negative_words, chars_checked, mismatches);
		$display("input held off for %0d cycles under output backpressure", input_stall_cycles);
		if (mismatches == 0) begin
			$display("signed_int_to_decimal_ascii_tb: clean");
		end else begin
			$display("signed_int_to_decimal_ascii_tb: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

### signed_int_to_decimal_ascii.f
hw/rtl/sida_pkg.sv
hw/rtl/sida_dabble_stage.sv
hw/rtl/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
